[design/time_of_day_clock_with_capture_top_assert.svh]
// Assertion macros for the time-of-day clock block.
// Used by the design modules; no other dependencies.
`ifndef TIME_OF_DAY_CLOCK_WITH_CAPTURE_TOP_ASSERT_SVH
`define TIME_OF_DAY_CLOCK_WITH_CAPTURE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// clocked assertion, disabled while reset is high
`define TDC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked assertion, active during reset too
`define TDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDC_ASSERT(lbl, clk, rst, prop, msg)
`define TDC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/tdc_pkg.sv]
// Shared types, codes and constants for the time-of-day clock block.
// No dependencies.
package tdc_pkg;

   localparam int TDC_COUNT_WIDTH = 16;
   localparam int TDC_TICKS_WIDTH = 16;
   localparam logic [TDC_TICKS_WIDTH-1:0] TDC_TICKS_RESET = 16'd1000;

   localparam int SECS_PER_MIN  = 60;
   localparam int MINS_PER_HOUR = 60;
   localparam int HOURS_PER_DAY = 24;

   // transaction function codes
   localparam logic [1:0] FUNC_SECOND = 2'd0;
   localparam logic [1:0] FUNC_FAST   = 2'd1;
   localparam logic [1:0] FUNC_EDGE   = 2'd2;
   localparam logic [1:0] FUNC_SET    = 2'd3;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } tdc_time_type;

   typedef struct packed {
      logic [1:0] func;
      logic       dark;
      logic [6:0] set_hours;
      logic [6:0] set_minutes;
      logic [6:0] set_seconds;
   } tdc_cmd_type;

   // one step of the state, issued as the input stage hands over
   typedef struct packed {
      logic        fire;
      tdc_cmd_type cmd;
   } tdc_step_type;

endpackage

[design/tdc_ifs.sv]
// Channel interfaces: request, response and CSR write.
// Depends on tdc_pkg.
interface tdc_req_if import tdc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic       light_sensor_dark;
   logic [6:0] set_hours;
   logic [6:0] set_minutes;
   logic [6:0] set_seconds;

   modport source (output valid, func, light_sensor_dark, set_hours, set_minutes,
                   set_seconds, input ready);
   modport sink   (input valid, func, light_sensor_dark, set_hours, set_minutes,
                   set_seconds, output ready);
endinterface

interface tdc_rsp_if import tdc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [4:0] hours;
   logic [5:0] minutes;
   logic [5:0] seconds;
   logic [4:0] sunrise_hours;
   logic [5:0] sunrise_minutes;
   logic [5:0] sunrise_seconds;
   logic [4:0] sunset_hours;
   logic [5:0] sunset_minutes;
   logic [5:0] sunset_seconds;
   logic       debounce_pending;

   modport source (output valid, hours, minutes, seconds, sunrise_hours, sunrise_minutes,
                   sunrise_seconds, sunset_hours, sunset_minutes, sunset_seconds,
                   debounce_pending, input ready);
   modport sink   (input valid, hours, minutes, seconds, sunrise_hours, sunrise_minutes,
                   sunrise_seconds, sunset_hours, sunset_minutes, sunset_seconds,
                   debounce_pending, output ready);
endinterface

interface tdc_csr_if import tdc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [TDC_TICKS_WIDTH-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[design/tdc_time_keeper.sv]
// Time-of-day register with second advance and range-checked set.
// Depends on tdc_pkg and the assertion header.
`include "time_of_day_clock_with_capture_top_assert.svh"

module tdc_time_keeper import tdc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  tdc_step_type step,
   output tdc_time_type time_now,
   output tdc_time_type time_next
);

   tdc_time_type cur_ff;
   tdc_time_type cur_in;

   always_comb begin
      cur_in = cur_ff;
      unique case (step.cmd.func)
         FUNC_SECOND: begin
            if (7'({1'b0, cur_ff.seconds}) + 7'd1 < 7'(SECS_PER_MIN)) begin
               cur_in.seconds = cur_ff.seconds + 6'd1;
            end else begin
               cur_in.seconds = '0;
               if (7'({1'b0, cur_ff.minutes}) + 7'd1 < 7'(MINS_PER_HOUR)) begin
                  cur_in.minutes = cur_ff.minutes + 6'd1;
               end else begin
                  cur_in.minutes = '0;
                  if (6'({1'b0, cur_ff.hours}) + 6'd1 < 6'(HOURS_PER_DAY)) begin
                     cur_in.hours = cur_ff.hours + 5'd1;
                  end else begin
                     cur_in.hours = '0;
                  end
               end
            end
         end
         FUNC_SET: begin
            // each field loads on its own, only when in range
            if (step.cmd.set_hours < 7'(HOURS_PER_DAY)) cur_in.hours = step.cmd.set_hours[4:0];
            if (step.cmd.set_minutes < 7'(MINS_PER_HOUR)) begin
               cur_in.minutes = step.cmd.set_minutes[5:0];
            end
            if (step.cmd.set_seconds < 7'(SECS_PER_MIN)) begin
               cur_in.seconds = step.cmd.set_seconds[5:0];
            end
         end
         default: begin
            cur_in = cur_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else if (step.fire) begin
         cur_ff <= cur_in;
      end
   end

   assign time_now  = cur_ff;
   assign time_next = cur_in;

   `TDC_ASSERT(hours_range_a, clock, reset, cur_ff.hours < 5'(HOURS_PER_DAY), "hours range")
   `TDC_ASSERT(minutes_range_a, clock, reset, cur_ff.minutes < 6'(MINS_PER_HOUR), "minutes range")
   `TDC_ASSERT(seconds_range_a, clock, reset, cur_ff.seconds < 6'(SECS_PER_MIN), "seconds range")

endmodule

[design/tdc_debounce.sv]
// Sensor-edge debounce counter with sunrise/sunset capture registers.
// Depends on tdc_pkg and the assertion header.
`include "time_of_day_clock_with_capture_top_assert.svh"

module tdc_debounce import tdc_pkg::*; #(
   parameter int COUNT_WIDTH = TDC_COUNT_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tdc_step_type               step,
   input  tdc_time_type               time_now,
   input  logic [TDC_TICKS_WIDTH-1:0] debounce_ticks,
   output tdc_time_type               sunrise_next,
   output tdc_time_type               sunset_next,
   output logic                       armed_next
);

   localparam int CMP_WIDTH = (COUNT_WIDTH > TDC_TICKS_WIDTH) ? COUNT_WIDTH : TDC_TICKS_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic                   armed_ff, armed_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   tdc_time_type           sunrise_ff, sunrise_in;
   tdc_time_type           sunset_ff, sunset_in;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic                   sample_hit;

   // saturating increment; full count forces the sample
   assign count_inc  = (count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   assign sample_hit = (CMP_WIDTH'(count_inc) >= CMP_WIDTH'(debounce_ticks)) ||
                       (count_inc == COUNT_MAX);

   always_comb begin
      armed_in   = armed_ff;
      count_in   = count_ff;
      sunrise_in = sunrise_ff;
      sunset_in  = sunset_ff;
      unique case (step.cmd.func)
         FUNC_FAST: begin
            if (armed_ff) begin
               count_in = count_inc;
               if (sample_hit) begin
                  armed_in = 1'b0;
                  if (step.cmd.dark) sunset_in = time_now;
                  else sunrise_in = time_now;
               end
            end
         end
         FUNC_EDGE: begin
            armed_in = 1'b1;
            count_in = '0;
         end
         default: begin
            armed_in = armed_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff   <= 1'b0;
         count_ff   <= '0;
         sunrise_ff <= '0;
         sunset_ff  <= '0;
      end else if (step.fire) begin
         armed_ff   <= armed_in;
         count_ff   <= count_in;
         sunrise_ff <= sunrise_in;
         sunset_ff  <= sunset_in;
      end
   end

   assign sunrise_next = sunrise_in;
   assign sunset_next  = sunset_in;
   assign armed_next   = armed_in;

   `TDC_ASSERT(no_capture_disarmed_a, clock, reset, (step.fire && !armed_ff) |=> ($stable(sunrise_ff) && $stable(sunset_ff)), "capture while disarmed")

endmodule

[design/time_of_day_clock_with_capture_top.sv]
// Top level of the time-of-day clock with sunrise/sunset capture.
// Depends on tdc_pkg, tdc_ifs, tdc_time_keeper, tdc_debounce and the assertion header.
//
// Keeps a 24-hour hh:mm:ss time and captures it as sunrise or sunset once a
// light-sensor edge has been debounced over a configurable number of fast ticks.
// Every request transaction (second tick, fast tick, sensor edge, set time)
// yields exactly one response transaction carrying the time, both captures and
// the debounce-pending flag as they stand after that request. One request is
// taken every cycle while response back-pressure does not hold the flow; each
// passes through the input register, then the response register, with the
// state update done combinationally between those two registers.
// Response back-pressure stalls the input register, which then holds one
// transaction; req ready drops only while both registers are full and the
// response is not being taken. The CSR port (debounce_ticks, reset 1000) is
// always ready; the user must write it only while idle, which the block does not enforce.
`include "time_of_day_clock_with_capture_top_assert.svh"

module time_of_day_clock_with_capture_top import tdc_pkg::*; #(
   parameter int COUNT_WIDTH = TDC_COUNT_WIDTH
) (
   input  logic  clock,
   input  logic  reset,
   tdc_req_if.sink   req_port,
   tdc_rsp_if.source rsp_port,
   tdc_csr_if.sink   csr_port
);

   typedef struct packed {
      tdc_time_type now;
      tdc_time_type sunrise;
      tdc_time_type sunset;
      logic         pending;
   } rsp_payload_type;

   // input stage
   logic        in_valid_ff;
   tdc_cmd_type in_cmd_ff;
   logic        advance;
   logic        req_ready;

   // response stage
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;

   // configuration
   logic [TDC_TICKS_WIDTH-1:0] ticks_ff;

   tdc_step_type step;
   tdc_time_type time_now, time_next;
   tdc_time_type sunrise_next, sunset_next;
   logic         armed_next;

   // input stage hands its transaction over whenever the response slot frees
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_port.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_ready) begin
         in_cmd_ff.func        <= req_port.func;
         in_cmd_ff.dark        <= req_port.light_sensor_dark;
         in_cmd_ff.set_hours   <= req_port.set_hours;
         in_cmd_ff.set_minutes <= req_port.set_minutes;
         in_cmd_ff.set_seconds <= req_port.set_seconds;
      end
   end

   // CSR: single register, no address
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= TDC_TICKS_RESET;
      end else if (csr_port.valid) begin
         ticks_ff <= csr_port.data;
      end
   end

   assign step.fire = advance;
   assign step.cmd  = in_cmd_ff;

   tdc_time_keeper u_time (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .time_now  (time_now),
      .time_next (time_next)
   );

   tdc_debounce #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_debounce (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .time_now       (time_now),
      .debounce_ticks (ticks_ff),
      .sunrise_next   (sunrise_next),
      .sunset_next    (sunset_next),
      .armed_next     (armed_next)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff.now     <= time_next;
         rsp_ff.sunrise <= sunrise_next;
         rsp_ff.sunset  <= sunset_next;
         rsp_ff.pending <= armed_next;
      end
   end

   assign rsp_port.valid            = rsp_valid_ff;
   assign rsp_port.hours            = rsp_ff.now.hours;
   assign rsp_port.minutes          = rsp_ff.now.minutes;
   assign rsp_port.seconds          = rsp_ff.now.seconds;
   assign rsp_port.sunrise_hours    = rsp_ff.sunrise.hours;
   assign rsp_port.sunrise_minutes  = rsp_ff.sunrise.minutes;
   assign rsp_port.sunrise_seconds  = rsp_ff.sunrise.seconds;
   assign rsp_port.sunset_hours     = rsp_ff.sunset.hours;
   assign rsp_port.sunset_minutes   = rsp_ff.sunset.minutes;
   assign rsp_port.sunset_seconds   = rsp_ff.sunset.seconds;
   assign rsp_port.debounce_pending = rsp_ff.pending;

   // a stalled input transaction must stay put, not be dropped or altered
   `TDC_ASSERT(in_hold_a, clock, reset, (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_cmd_ff)), "input transaction lost while stalled")
   // every hand-over lands in the response register
   `TDC_ASSERT(rsp_load_a, clock, reset, advance |=> rsp_valid_ff, "response not raised after hand-over")

endmodule
